// ===== src/wsfd_pkg.sv =====
package wsfd_pkg;

	localparam int LEN_W = 64;
	localparam int KEY_W = 32;

	// parse phases
	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_MASK = 3'd3;
	localparam logic [2:0] PH_PAY  = 3'd4;

	localparam logic [3:0] OP_CLOSE = 4'd8;
	localparam logic [3:0] OP_PING  = 4'd9;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	// extension counts hold bytes still to read minus one
	localparam logic [2:0] EXT16_LAST = 3'd1;
	localparam logic [2:0] EXT64_LAST = 3'd7;
	localparam logic [2:0] KEY_LAST   = 3'd3;

	localparam logic [6:0] CTRL_MAX_RESET = 7'd125;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_PONG  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} wsfd_item_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
		logic       closed;
	} wsfd_res_t;

endpackage

// ===== src/wsfd_in_stage.sv =====
module wsfd_in_stage
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       adv,
	output logic       valid_s1,
	output wsfd_item_t item_s1
);

	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data <= s_tdata;
			item_s1.last <= s_tlast;
		end
	end

endmodule

// ===== src/wsfd_parser.sv =====
module wsfd_parser
	import wsfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       adv,
	input  wsfd_item_t item_s1,
	output wsfd_res_t  res,
	output logic       ended
);

	logic [6:0]       ctrl_max_q;
	logic [2:0]       phase_q, phase_nxt;
	logic [2:0]       ext_q, ext_nxt;
	logic [LEN_W-1:0] len_q, len_nxt;
	logic [KEY_W-1:0] key_q, key_nxt;
	logic [1:0]       midx_q, midx_nxt;
	logic             masked_q, masked_nxt;
	logic [3:0]       opcode_q, opcode_nxt;
	logic [LEN_W-1:0] rem_q, rem_nxt;
	logic             ended_q, ended_nxt;

	logic             hd_trig;
	logic [LEN_W-1:0] hd_len;
	logic [LEN_W-1:0] len_shift;
	logic [LEN_W-1:0] rem_dec;
	logic [7:0]       key_byte;
	logic [7:0]       pay;
	logic             pay_last;
	logic             too_long;
	logic [7:0]       b;

	assign b         = item_s1.data;
	assign len_shift = {len_q[LEN_W-9:0], b};
	assign rem_dec   = rem_q - LEN_W'(1);
	assign pay_last  = (rem_dec == '0);
	assign ended     = ended_q;

	always_comb begin
		case (midx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		pay = masked_q ? (b ^ key_byte) : b;
	end

	always_comb begin
		phase_nxt  = phase_q;
		ext_nxt    = ext_q;
		len_nxt    = len_q;
		key_nxt    = key_q;
		midx_nxt   = midx_q;
		masked_nxt = masked_q;
		opcode_nxt = opcode_q;
		rem_nxt    = rem_q;
		ended_nxt  = ended_q;
		hd_trig    = 1'b0;
		hd_len     = len_q;
		too_long   = 1'b0;
		res        = '0;

		if (!ended_q) begin
			case (phase_q)
				PH_HDR1: begin
					masked_nxt = b[7];
					len_nxt    = {{(LEN_W-7){1'b0}}, b[6:0]};
					if (b[6:0] == LEN_CODE_16) begin
						len_nxt   = '0;
						ext_nxt   = EXT16_LAST;
						phase_nxt = PH_EXT;
					end else if (b[6:0] == LEN_CODE_64) begin
						len_nxt   = '0;
						ext_nxt   = EXT64_LAST;
						phase_nxt = PH_EXT;
					end else if (b[7]) begin
						ext_nxt   = KEY_LAST;
						phase_nxt = PH_MASK;
					end else begin
						hd_trig = 1'b1;
						hd_len  = {{(LEN_W-7){1'b0}}, b[6:0]};
					end
				end
				PH_EXT: begin
					len_nxt = len_shift;
					if (ext_q == 3'd0) begin
						if (masked_q) begin
							ext_nxt   = KEY_LAST;
							phase_nxt = PH_MASK;
						end else begin
							hd_trig = 1'b1;
							hd_len  = len_shift;
						end
					end else begin
						ext_nxt = ext_q - 3'd1;
					end
				end
				PH_MASK: begin
					key_nxt = {key_q[KEY_W-9:0], b};
					if (ext_q == 3'd0) begin
						hd_trig = 1'b1;
					end else begin
						ext_nxt = ext_q - 3'd1;
					end
				end
				PH_PAY: begin
					midx_nxt = midx_q + 2'd1;
					rem_nxt  = rem_dec;
					if (pay_last) begin
						phase_nxt = PH_HDR0;
					end
					if (opcode_q < OP_CLOSE) begin
						res.valid = 1'b1;
						res.kind  = KIND_DATA;
						res.data  = pay;
						res.last  = pay_last;
					end else if (opcode_q == OP_PING) begin
						res.valid = 1'b1;
						res.kind  = KIND_PONG;
						res.data  = pay;
						res.last  = pay_last;
					end else if (opcode_q == OP_CLOSE && pay_last) begin
						ended_nxt = 1'b1;
						res.valid = 1'b1;
						res.kind  = KIND_CLOSE;
					end
				end
				default: begin
					opcode_nxt = b[3:0];
					phase_nxt  = PH_HDR1;
				end
			endcase

			// header complete: check control length, then start a nonzero payload or end on an empty close frame
			if (hd_trig) begin
				phase_nxt = PH_HDR0;
				midx_nxt  = 2'd0;
				too_long  = (opcode_q >= OP_CLOSE) &&
					((|hd_len[LEN_W-1:7]) || (hd_len[6:0] > ctrl_max_q));
				if (too_long) begin
					ended_nxt = 1'b1;
					res.valid = 1'b1;
					res.kind  = KIND_ERROR;
				end else if (hd_len == '0) begin
					if (opcode_q == OP_CLOSE) begin
						ended_nxt = 1'b1;
						res.valid = 1'b1;
						res.kind  = KIND_CLOSE;
					end
				end else begin
					rem_nxt   = hd_len;
					phase_nxt = PH_PAY;
				end
			end

			if (item_s1.last) begin
				ended_nxt = 1'b1;
			end
		end
		res.closed = ended_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_max_q <= CTRL_MAX_RESET;
		end else if (cfg_we) begin
			ctrl_max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			ext_q    <= '0;
			len_q    <= '0;
			key_q    <= '0;
			midx_q   <= '0;
			masked_q <= 1'b0;
			opcode_q <= '0;
			rem_q    <= '0;
			ended_q  <= 1'b0;
		end else if (adv) begin
			phase_q  <= phase_nxt;
			ext_q    <= ext_nxt;
			len_q    <= len_nxt;
			key_q    <= key_nxt;
			midx_q   <= midx_nxt;
			masked_q <= masked_nxt;
			opcode_q <= opcode_nxt;
			rem_q    <= rem_nxt;
			ended_q  <= ended_nxt;
		end
	end

endmodule

// ===== src/wsfd_out_stage.sv =====
module wsfd_out_stage
	import wsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  wsfd_res_t   res,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       closed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= res.valid;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q   <= res.kind;
			data_q   <= res.data;
			last_q   <= res.last;
			closed_q <= res.closed;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'b0, closed_q, data_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

// ===== src/websocket_frame_decoder_top.sv =====
// websocket frame decoder: one received stream byte per transaction in, at most
// one decoded transaction out per byte
// s_tdata carries the raw byte, s_tlast marks the final byte the peer sends
// m_tdata[7:0] is the unmasked payload byte (zero for close and error),
// m_tdata[8] is stream_closed, m_tuser is the kind (data, pong, close, error)
// and m_tlast marks the final payload byte of a frame
// header bytes other than the last one of an over-long control or empty close header,
// dropped control payload and everything after the stream has ended produce no output transaction
// cfg_we/cfg_wdata load the largest accepted control frame length, write it
// only while the block is idle
// a result moves from the input register to the output register through the
// parse step, and the output register drives m_tvalid
// throughput: one byte per cycle while the output is not stalled, set by the
// combinational parse and unmask step between those two registers
// when m_tready is low with a result waiting the output register holds, and
// s_tready drops as soon as the input register is full until the result moves on
// reset clears the parser to expect a frame header and sets the length limit
// back to 125
module websocket_frame_decoder_top
	import wsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // payload_byte, stream_closed, zero fill
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast
);

	logic       valid_s1;
	wsfd_item_t item_s1;
	wsfd_res_t  res;
	logic       ended;
	logic       adv;

	assign adv = valid_s1 && (!m_tvalid || m_tready);

	wsfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wsfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.item_s1   (item_s1),
		.res       (res),
		.ended     (ended)
	);

	wsfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef ASSERT_OFF
	// once the stream has ended it stays ended until reset
	assert property (@(posedge clk) disable iff (!arst_n) ended |=> ended)
		else $error("stream end flag cleared");

	// a byte processed after the end yields no output
	assert property (@(posedge clk) disable iff (!arst_n) (ended && adv) |=> !m_tvalid)
		else $error("output after stream end");

	// close and error results always report the stream as closed, with zero data and m_tlast low
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_CLOSE || m_tuser == KIND_ERROR))
		|-> (m_tdata[8] && !m_tlast && m_tdata[7:0] == 8'd0))
		else $error("close or error result malformed");

	// a full input register facing a stalled output must block new bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while pipeline is stalled");
`endif

endmodule
